>>> sv/euq_pkg.sv
// ----------------------------------------------------------------------------
// euq_pkg
// Shared types, constants and helper functions for the escape unquoter.
// ----------------------------------------------------------------------------
package euq_pkg;

    localparam int MAX_OUT  = 10;
    localparam int CNT_W    = 4;
    localparam int NDIGITS  = 8;
    localparam int DIG_IDX_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE_CHAR = 2'd1;

    localparam logic       QUOTE_MODE_RESET = 1'b1;
    localparam logic [7:0] QUOTE_CHAR_RESET = 8'd34;

    // Character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U_LO   = 8'h75;
    localparam logic [7:0] CH_U_HI   = 8'h55;

    localparam logic [7:0] CTRL_BEL = 8'd7;
    localparam logic [7:0] CTRL_BS  = 8'd8;
    localparam logic [7:0] CTRL_FF  = 8'd12;
    localparam logic [7:0] CTRL_LF  = 8'd10;
    localparam logic [7:0] CTRL_CR  = 8'd13;
    localparam logic [7:0] CTRL_HT  = 8'd9;
    localparam logic [7:0] CTRL_VT  = 8'd11;

    localparam logic [3:0] NEED_X     = 4'd2;
    localparam logic [3:0] NEED_U_LO  = 4'd4;
    localparam logic [3:0] NEED_U_HI  = 4'd8;
    localparam logic [3:0] OCT_DIGITS = 4'd3;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_ESC    = 2'd1,
        PH_OCT    = 2'd2,
        PH_HEX    = 2'd3
    } phase_t;

    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
    } result_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic utf8_t utf8_enc(input logic [31:0] cp);
        utf8_t r;
        r.b = '0;
        if (cp[31] || cp <= 32'h0000_007F) begin
            r.n    = 3'd1;
            r.b[0] = cp[7:0];
        end
        else if (cp <= 32'h0000_07FF) begin
            r.n    = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 32'h0000_FFFF) begin
            r.n    = 3'd3;
            r.b[0] = {4'hE, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end
        else begin
            // lead byte is not range checked: upper bits fold into it
            r.n    = 3'd4;
            r.b[0] = 8'hF0 | cp[25:18];
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r.val = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r.val = 4'(c - 8'h57);
        end
        else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> sv/euq_decode.sv
// ----------------------------------------------------------------------------
// euq_decode
// Decode state and the single-pass expansion of one input byte into its
// list of output bytes.
// ----------------------------------------------------------------------------
module euq_decode (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [7:0]                      in_byte,
    input  logic                            in_last,
    input  logic                            quote_mode,
    input  logic [7:0]                      quote_char,
    input  logic                            cfg_clear,
    output euq_pkg::result_t                result
);
    import euq_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        skip_reg, skip_next;
    logic [31:0] cv_reg, cv_next;
    logic [3:0]  seen_reg, seen_next;
    logic [3:0]  need_reg, need_next;
    logic [7:0]  letter_reg, letter_next;
    logic [NDIGITS-1:0][7:0] pend_reg, pend_next;
    logic        pend_we;

    always_comb
    begin
        logic [MAX_OUT-1:0][7:0] ob;
        logic [CNT_W-1:0]        oc;
        hex_t                    hx;
        utf8_t                   enc;
        logic                    is_oct;
        logic                    emit_one;
        logic [7:0]              one_byte;
        logic                    emit_u;
        logic                    emit_f;
        logic                    plain_go;
        logic                    tail_bs;

        phase_next  = phase_reg;
        skip_next   = skip_reg;
        cv_next     = cv_reg;
        seen_next   = seen_reg;
        need_next   = need_reg;
        letter_next = letter_reg;
        pend_we     = 1'b0;
        ob          = '0;
        oc          = '0;
        hx          = hex_digit(in_byte);
        is_oct      = (in_byte[7:3] == 5'b00110);
        emit_one    = 1'b0;
        one_byte    = in_byte;
        emit_u      = 1'b0;
        emit_f      = 1'b0;
        plain_go    = 1'b0;
        tail_bs     = 1'b0;

        if (!quote_mode) begin
            if (skip_reg) begin
                skip_next = 1'b0;
            end
            else begin
                emit_one = 1'b1;
                if (in_byte == quote_char) begin
                    skip_next = 1'b1;
                end
            end
        end
        else begin
            unique case (phase_reg)
                PH_ESC:
                begin
                    phase_next = PH_NORMAL;
                    case (in_byte)
                        CH_A: begin emit_one = 1'b1; one_byte = CTRL_BEL; end
                        CH_B: begin emit_one = 1'b1; one_byte = CTRL_BS;  end
                        CH_F: begin emit_one = 1'b1; one_byte = CTRL_FF;  end
                        CH_N: begin emit_one = 1'b1; one_byte = CTRL_LF;  end
                        CH_R: begin emit_one = 1'b1; one_byte = CTRL_CR;  end
                        CH_T: begin emit_one = 1'b1; one_byte = CTRL_HT;  end
                        CH_V: begin emit_one = 1'b1; one_byte = CTRL_VT;  end
                        CH_X, CH_U_LO, CH_U_HI:
                        begin
                            phase_next  = PH_HEX;
                            letter_next = in_byte;
                            need_next   = (in_byte == CH_X)    ? NEED_X :
                                          (in_byte == CH_U_LO) ? NEED_U_LO : NEED_U_HI;
                            seen_next   = 4'd0;
                            cv_next     = 32'd0;
                        end
                        default:
                        begin
                            if (is_oct) begin
                                phase_next = PH_OCT;
                                cv_next    = {29'd0, in_byte[2:0]};
                                seen_next  = 4'd1;
                            end
                            else begin
                                emit_one = 1'b1;
                            end
                        end
                    endcase
                end
                PH_OCT:
                begin
                    if (is_oct) begin
                        cv_next   = {cv_reg[28:0], in_byte[2:0]};
                        seen_next = seen_reg + 4'd1;
                        if (seen_next >= OCT_DIGITS) begin
                            emit_u     = 1'b1;
                            phase_next = PH_NORMAL;
                        end
                    end
                    else begin
                        emit_u     = 1'b1;
                        phase_next = PH_NORMAL;
                        plain_go   = 1'b1;
                    end
                end
                PH_HEX:
                begin
                    if (hx.ok) begin
                        pend_we   = 1'b1;
                        cv_next   = {cv_reg[27:0], hx.val};
                        seen_next = seen_reg + 4'd1;
                        if (seen_next >= need_reg) begin
                            emit_u     = 1'b1;
                            phase_next = PH_NORMAL;
                        end
                    end
                    else begin
                        emit_f     = 1'b1;
                        phase_next = PH_NORMAL;
                        plain_go   = 1'b1;
                    end
                end
                default:
                begin
                    plain_go = 1'b1;
                end
            endcase

            if (plain_go) begin
                if (in_byte == CH_BSLASH) begin
                    phase_next = PH_ESC;
                end
                else begin
                    emit_one = 1'b1;
                end
            end

            // field ends inside an escape: close it out
            if (in_last) begin
                case (phase_next)
                    PH_ESC:  tail_bs = 1'b1;
                    PH_OCT:  emit_u  = 1'b1;
                    PH_HEX:  emit_f  = 1'b1;
                    default: tail_bs = 1'b0;
                endcase
            end
        end

        // digit store as it stands after this byte
        for (int i = 0; i < NDIGITS; i++) begin
            pend_next[i] = (pend_we && seen_reg[DIG_IDX_W-1:0] == DIG_IDX_W'(i))
                         ? in_byte : pend_reg[i];
        end

        // a value emission always uses the updated code value
        enc = utf8_enc(cv_next);

        // emissions never overlap beyond this order
        if (emit_u) begin
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < enc.n) begin
                    ob[oc] = enc.b[i];
                    oc     = oc + 4'd1;
                end
            end
        end
        if (emit_f) begin
            ob[oc] = CH_BSLASH;
            oc     = oc + 4'd1;
            ob[oc] = letter_next;
            oc     = oc + 4'd1;
            for (int i = 0; i < NDIGITS; i++) begin
                if (4'(i) < seen_next) begin
                    ob[oc] = pend_next[i];
                    oc     = oc + 4'd1;
                end
            end
        end
        if (emit_one) begin
            ob[oc] = one_byte;
            oc     = oc + 4'd1;
        end
        if (tail_bs) begin
            ob[oc] = CH_BSLASH;
            oc     = oc + 4'd1;
        end

        if (in_last) begin
            phase_next  = PH_NORMAL;
            skip_next   = 1'b0;
            cv_next     = 32'd0;
            seen_next   = 4'd0;
            need_next   = 4'd0;
            letter_next = 8'd0;
        end

        result.bytes = ob;
        result.count = oc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_NORMAL;
            skip_reg   <= 1'b0;
            cv_reg     <= 32'd0;
            seen_reg   <= 4'd0;
            need_reg   <= 4'd0;
            letter_reg <= 8'd0;
        end
        else if (cfg_clear) begin
            phase_reg  <= PH_NORMAL;
            skip_reg   <= 1'b0;
            cv_reg     <= 32'd0;
            seen_reg   <= 4'd0;
            need_reg   <= 4'd0;
            letter_reg <= 8'd0;
        end
        else if (accept) begin
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            cv_reg     <= cv_next;
            seen_reg   <= seen_next;
            need_reg   <= need_next;
            letter_reg <= letter_next;
        end
    end

    // digit store holds payload only; entries are read after being written
    always_ff @(posedge clk)
    begin
        if (accept) begin
            pend_reg <= pend_next;
        end
    end

endmodule

>>> sv/escape_unquote_to_utf8_core.sv
// ----------------------------------------------------------------------------
// escape_unquote_to_utf8_core
// Quoted field body unescaper: doubled quotes or backslash escapes in,
// UTF-8 bytes out.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     in_valid/in_ready: in_byte, in_last       in
//  output    out_valid/out_ready: out_byte,            out
//            byte_valid, out_last
//  config    cfg_we, cfg_index, cfg_data               in
//
//  Each input byte is expanded into a result buffer of up to ten bytes,
//  which drains one byte per cycle while out_ready holds. A byte yielding
//  one result sustains one transaction per cycle on the same condition; a
//  byte yielding n results holds the single output port until all n are
//  taken. Input is taken when the buffer is empty or its last byte is taken.
//  Reset empties the buffer, clears decode state and loads default registers.
// ----------------------------------------------------------------------------
module escape_unquote_to_utf8_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_byte,
    input  logic                             in_last,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic                             byte_valid,
    output logic                             out_last,
    input  logic                             cfg_we,
    input  logic [euq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [euq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import euq_pkg::*;

    logic                    quote_mode_reg;
    logic [7:0]              quote_char_reg;
    logic [MAX_OUT-1:0][7:0] buf_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    last_reg;
    logic                    bare_reg;
    logic                    accept;
    logic                    take;
    logic                    cfg_clear;
    result_t                 result;

    assign take      = out_valid && out_ready;
    assign in_ready  = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && out_ready);
    assign accept    = in_valid && in_ready;
    assign cfg_clear = cfg_we && (cfg_index == REG_QUOTE_MODE || cfg_index == REG_QUOTE_CHAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            quote_mode_reg <= QUOTE_MODE_RESET;
            quote_char_reg <= QUOTE_CHAR_RESET;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                REG_QUOTE_MODE: quote_mode_reg <= cfg_data[0];
                REG_QUOTE_CHAR: quote_char_reg <= cfg_data[7:0];
                default:        quote_mode_reg <= quote_mode_reg;
            endcase
        end
    end

    euq_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .quote_mode (quote_mode_reg),
        .quote_char (quote_char_reg),
        .cfg_clear  (cfg_clear),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            last_reg <= 1'b0;
            bare_reg <= 1'b0;
        end
        else if (accept) begin
            last_reg <= in_last;
            if (result.count == '0) begin
                // a silent final byte still closes the field with a marker
                cnt_reg  <= in_last ? CNT_W'(1) : '0;
                bare_reg <= 1'b1;
            end
            else begin
                cnt_reg  <= result.count;
                bare_reg <= 1'b0;
            end
        end
        else if (take) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            buf_reg <= result.bytes;
        end
        else if (take) begin
            // advance the next byte to the head
            buf_reg <= {8'd0, buf_reg[MAX_OUT-1:1]};
        end
    end

    assign out_valid  = (cnt_reg != '0);
    assign out_byte   = bare_reg ? 8'd0 : buf_reg[0];
    assign byte_valid = !bare_reg;
    assign out_last   = last_reg && (cnt_reg == CNT_W'(1));

endmodule

>>> sv/euq_checker.sv
// ----------------------------------------------------------------------------
// euq_checker
// Port-level checks for the escape unquoter, bound to the top level.
// ----------------------------------------------------------------------------
module euq_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             in_last,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [7:0]                       out_byte,
    input  logic                             byte_valid,
    input  logic                             out_last
);

    // a stalled transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("output transaction dropped or changed while stalled");

    // a bare marker only closes a field
    a_bare_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_last)
        else $error("bare marker without field end");

    a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'd0)
        else $error("bare marker carries a nonzero byte");

    // every field end produces a result on the next cycle
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> out_valid)
        else $error("field end produced no result");

    // no new input while a queued result is stalled
    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

endmodule

bind escape_unquote_to_utf8_core euq_checker u_euq_checker (.*);
